>>> src/nvbp_pkg.sv
// Shared types and constants of the name/value block parser.
package nvbp_pkg;

    localparam int unsigned TOTAL_W   = 24;
    localparam int unsigned CFG_DW    = 24;
    localparam int unsigned SIZE_W    = 3;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 24'hFF_FFFF;
    localparam logic [TOTAL_W-1:0] LIMIT_RESET   = 24'd81920;
    localparam logic [SIZE_W-1:0]  SIZE_RESET    = 3'd4;
    localparam logic [SIZE_W-1:0]  SIZE_SHORT    = 3'd2;

    // register indexes on the configuration port
    localparam logic CFG_SIZE_FIELD = 1'b0;
    localparam logic CFG_EXP_LIMIT  = 1'b1;

    // parse status codes
    localparam logic [2:0] ST_BUSY        = 3'd0;
    localparam logic [2:0] ST_DONE        = 3'd1;
    localparam logic [2:0] ST_BAD         = 3'd2;
    localparam logic [2:0] ST_EMPTY_NAME  = 3'd3;
    localparam logic [2:0] ST_BAD_NAME    = 3'd4;
    localparam logic [2:0] ST_EMPTY_VALUE = 3'd5;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd6;

    // byte role codes
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;
    localparam logic [1:0] KIND_SEP   = 2'd3;

    // name byte bounds
    localparam logic [7:0] CHR_LOW   = 8'h20;
    localparam logic [7:0] CHR_HIGH  = 8'h7e;
    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_UP_Z  = 8'h5a;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    typedef enum logic [3:0] {
        PH_COUNT = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_STR   = 4'b0100,
        PH_IDLE  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [SIZE_W-1:0]  size_bytes;
        logic [TOTAL_W-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [1:0]         byte_kind;
        logic               string_end;
        logic [2:0]         parse_status;
        logic [TOTAL_W-1:0] expanded_bytes;
    } t_result;

endpackage

>>> src/nvbp_core.sv
// Parse state registers and the per-byte next-state logic.
module nvbp_core
    import nvbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step,
    input  logic [7:0] i_byte,
    input  logic    i_last,
    output t_result o_result
);

    t_phase             r_phase,   n_phase;
    logic [1:0]         r_idx,     n_idx;
    logic [31:0]        r_acc,     n_acc;
    logic [32:0]        r_strings, n_strings;
    logic [31:0]        r_sleft,   n_sleft;
    logic [31:0]        r_name,    n_name;
    logic [31:0]        r_piece,   n_piece;
    logic               r_sep,     n_sep;
    logic               r_pne,     n_pne;
    logic               r_pve,     n_pve;
    logic [TOTAL_W-1:0] r_total,   n_total;
    logic [2:0]         r_status,  n_status;

    function automatic logic [2:0] fin_status(input logic [TOTAL_W-1:0] tot,
                                              input logic [TOTAL_W-1:0] lim);
        fin_status = (tot > lim) ? ST_TOO_LARGE : ST_DONE;
    endfunction

    always_comb begin
        logic [31:0]  acc;
        logic         is_name;
        logic         nul;
        logic [31:0]  sleft;
        logic [31:0]  piece_for;
        logic [32:0]  strs;
        logic [1:0]   idx_last;
        logic         use_a;
        logic         use_b;
        logic [34:0]  term_a;
        logic [34:0]  term_b;
        logic [34:0]  sum;
        logic [TOTAL_W-1:0] tot;
        logic         pve_end;

        n_phase   = r_phase;
        n_idx     = r_idx;
        n_acc     = r_acc;
        n_strings = r_strings;
        n_sleft   = r_sleft;
        n_name    = r_name;
        n_piece   = r_piece;
        n_sep     = r_sep;
        n_pne     = r_pne;
        n_pve     = r_pve;
        n_total   = r_total;
        n_status  = r_status;

        o_result.out_byte   = i_byte;
        o_result.byte_kind  = KIND_FRAME;
        o_result.string_end = 1'b0;

        acc       = {r_acc[23:0], i_byte};
        is_name   = ~r_strings[0];
        nul       = (i_byte == CHR_NUL);
        sleft     = r_sleft - 32'd1;
        piece_for = nul ? r_piece : r_piece + 32'd1;
        strs      = r_strings - 33'd1;
        idx_last  = (i_cfg.size_bytes == SIZE_SHORT) ? 2'd1 : 2'd3;

        // a NUL that also ends the value adds twice once a separator was seen; saturation lets both fold into one sum
        use_a  = r_sep && (nul || (sleft == 32'd0));
        use_b  = nul && (sleft == 32'd0);
        term_a = use_a ? ({3'b0, piece_for} + {3'b0, r_name}) : 35'd0;
        term_b = use_b ? {3'b0, r_name} : 35'd0;
        sum    = {11'b0, r_total} + term_a + term_b;
        tot    = (sum > {11'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        pve_end = r_pve || nul;

        if (r_status == ST_BUSY) begin
            case (r_phase)
                PH_COUNT, PH_LEN: begin
                    n_acc = acc;
                    if (r_idx >= idx_last) begin
                        if (r_phase == PH_COUNT) begin
                            n_strings = {acc, 1'b0};
                            if (acc == 32'd0) begin
                                n_status = fin_status(r_total, i_cfg.limit);
                                n_phase  = PH_IDLE;
                            end else begin
                                n_phase = PH_LEN;
                                n_idx   = 2'd0;
                                n_acc   = 32'd0;
                            end
                        end else if (is_name) begin
                            if (acc == 32'd0) begin
                                n_status = ST_EMPTY_NAME;
                                n_phase  = PH_IDLE;
                            end else begin
                                n_name  = acc;
                                n_pne   = 1'b0;
                                n_phase = PH_STR;
                                n_sleft = acc;
                            end
                        end else begin
                            n_piece = 32'd0;
                            n_sep   = 1'b0;
                            n_pve   = 1'b0;
                            if (acc == 32'd0) begin
                                // empty value completes on its length field
                                o_result.string_end = 1'b1;
                                n_strings = strs;
                                if (strs == 33'd0) begin
                                    n_status = fin_status(r_total, i_cfg.limit);
                                    n_phase  = PH_IDLE;
                                end else begin
                                    n_phase = PH_LEN;
                                    n_idx   = 2'd0;
                                    n_acc   = 32'd0;
                                end
                            end else begin
                                n_phase = PH_STR;
                                n_sleft = acc;
                            end
                        end
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
                PH_STR: begin
                    n_sleft = sleft;
                    if (is_name) begin
                        o_result.byte_kind = KIND_NAME;
                        if (i_byte < CHR_LOW || i_byte > CHR_HIGH ||
                            (i_byte inside {[CHR_UP_A:CHR_UP_Z]})) begin
                            n_pne = 1'b1;
                        end
                        if (sleft == 32'd0) begin
                            o_result.string_end = 1'b1;
                            if (n_pne) begin
                                n_status = ST_BAD_NAME;
                                n_phase  = PH_IDLE;
                            end else begin
                                n_strings = strs;
                                if (strs == 33'd0) begin
                                    n_status = fin_status(r_total, i_cfg.limit);
                                    n_phase  = PH_IDLE;
                                end else begin
                                    n_phase = PH_LEN;
                                    n_idx   = 2'd0;
                                    n_acc   = 32'd0;
                                end
                            end
                        end
                    end else begin
                        n_total = tot;
                        if (nul) begin
                            o_result.byte_kind = KIND_SEP;
                            if (r_piece == 32'd0) begin
                                n_pve = 1'b1;
                            end
                            n_sep   = 1'b1;
                            n_piece = 32'd0;
                        end else begin
                            o_result.byte_kind = KIND_VALUE;
                            n_piece = piece_for;
                        end
                        if (sleft == 32'd0) begin
                            o_result.string_end = 1'b1;
                            n_pve = pve_end;
                            if (pve_end) begin
                                n_status = ST_EMPTY_VALUE;
                                n_phase  = PH_IDLE;
                            end else begin
                                n_strings = strs;
                                if (strs == 33'd0) begin
                                    n_status = fin_status(tot, i_cfg.limit);
                                    n_phase  = PH_IDLE;
                                end else begin
                                    n_phase = PH_LEN;
                                    n_idx   = 2'd0;
                                    n_acc   = 32'd0;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (i_last && n_status == ST_BUSY) begin
            n_status = ST_BAD;
        end

        o_result.parse_status   = n_status;
        o_result.expanded_bytes = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase   <= PH_COUNT;
            r_idx     <= 2'd0;
            r_acc     <= 32'd0;
            r_strings <= 33'd0;
            r_sleft   <= 32'd0;
            r_name    <= 32'd0;
            r_piece   <= 32'd0;
            r_sep     <= 1'b0;
            r_pne     <= 1'b0;
            r_pve     <= 1'b0;
            r_total   <= '0;
            r_status  <= ST_BUSY;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_acc     <= n_acc;
            r_strings <= n_strings;
            r_sleft   <= n_sleft;
            r_name    <= n_name;
            r_piece   <= n_piece;
            r_sep     <= n_sep;
            r_pne     <= n_pne;
            r_pve     <= n_pve;
            r_total   <= n_total;
            r_status  <= n_status;
        end
    end

endmodule

>>> src/name_value_block_parser_top.sv
// Top level: input register, parse core, result register and configuration.
// A byte is held in the input register and then passes through the parse core into
// the result register, one byte per cycle while the result side is not stalled; the parse
// state updates once per byte as it moves from the input register into the result register.
// Reset (synchronous, active low) empties both registers, returns the parse state to
// reading the pair count, and sets the field width to 4 bytes and the limit to 81920.
module name_value_block_parser_top
    import nvbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_block_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic [1:0]         o_byte_kind,
    output logic               o_string_end,
    output logic [2:0]         o_parse_status,
    output logic [TOTAL_W-1:0] o_expanded_bytes,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_DW-1:0]  i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    t_result     step_res;
    t_cfg        r_cfg;
    logic        advance;
    logic        in_take;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_bytes <= SIZE_RESET;
            r_cfg.limit      <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIZE_FIELD: r_cfg.size_bytes <= i_cfg_data[SIZE_W-1:0];
                CFG_EXP_LIMIT:  r_cfg.limit      <= i_cfg_data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    // input register: hold while the result side backs up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_block_last;
        end
    end

    nvbp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (step_res)
    );

    // result register: drop the transaction once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_byte       = r_out.out_byte;
    assign o_byte_kind      = r_out.byte_kind;
    assign o_string_end     = r_out.string_end;
    assign o_parse_status   = r_out.parse_status;
    assign o_expanded_bytes = r_out.expanded_bytes;

`ifndef SYNTH
    a_sep_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_kind == KIND_SEP) |-> (o_out_byte == CHR_NUL))
        else $error("separator byte is not NUL");

    a_too_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_parse_status == ST_TOO_LARGE) |-> (o_expanded_bytes > r_cfg.limit))
        else $error("too large reported within limit");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a full pipeline");

    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("advanced byte did not reach the result register");
`endif

endmodule
